// File: design/tirc_pkg.sv
// ----------------------------------------------------------------------------
// tirc_pkg
// Shared codes and types for the two-image region compare mixer.
// ----------------------------------------------------------------------------
package tirc_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_SWAP_INPUTS  = 3'd1;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SIZE_X       = 3'd4;
    localparam logic [2:0] REG_SIZE_Y       = 3'd5;
    localparam logic [2:0] REG_POS_X        = 3'd6;
    localparam logic [2:0] REG_POS_Y        = 3'd7;

    // mixing modes, codes 5 to 7 pass the top image
    localparam logic [2:0] MODE_VERT    = 3'd0;
    localparam logic [2:0] MODE_HORIZ   = 3'd1;
    localparam logic [2:0] MODE_CIRCLE  = 3'd2;
    localparam logic [2:0] MODE_BOX     = 3'd3;
    localparam logic [2:0] MODE_CHECKER = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic       swap;
    } cfg_flags_t;

    // per-pixel raster decisions handed from the position tracker
    typedef struct packed {
        logic vert;
        logic band;
        logic frame_end;
    } pos_flags_t;

endpackage

// File: design/tirc_cfg.sv
// ----------------------------------------------------------------------------
// tirc_cfg
// Configuration registers and the effective (clamped) values derived from them.
// ----------------------------------------------------------------------------
module tirc_cfg #(
    parameter int COORD_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    output tirc_pkg::cfg_flags_t      flags,
    output logic [COORD_BITS-1:0]     eff_w,
    output logic [COORD_BITS-1:0]     eff_h,
    output logic [COORD_BITS-1:0]     eff_sx,
    output logic [COORD_BITS-1:0]     eff_sy,
    output logic [COORD_BITS-1:0]     eff_ox,
    output logic [COORD_BITS-1:0]     eff_oy,
    output logic [COORD_BITS-1:0]     box_x,
    output logic [COORD_BITS-1:0]     box_y,
    output logic [COORD_BITS-1:0]     pos_x,
    output logic [COORD_BITS-1:0]     pos_y,
    output logic [2*COORD_BITS-1:0]   radius_sq
);

    localparam int C = COORD_BITS;

    logic [2:0]     mode_reg;
    logic           swap_reg;
    logic [C-1:0]   frame_width_reg;
    logic [C-1:0]   frame_height_reg;
    logic [C-1:0]   size_x_reg;
    logic [C-1:0]   size_y_reg;
    logic [C-1:0]   pos_x_reg;
    logic [C-1:0]   pos_y_reg;
    logic [2*C-1:0] radius_sq_reg;
    logic [2*C-1:0] radius_sq_next;
    logic           wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= tirc_pkg::MODE_VERT;
            swap_reg         <= 1'b0;
            frame_width_reg  <= C'(640);
            frame_height_reg <= C'(480);
            size_x_reg       <= C'(64);
            size_y_reg       <= C'(48);
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
        end else if (wr) begin
            unique case (cfg_index)
                tirc_pkg::REG_MODE:         mode_reg         <= cfg_data[2:0];
                tirc_pkg::REG_SWAP_INPUTS:  swap_reg         <= cfg_data[0];
                tirc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                tirc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                tirc_pkg::REG_SIZE_X:       size_x_reg       <= cfg_data;
                tirc_pkg::REG_SIZE_Y:       size_y_reg       <= cfg_data;
                tirc_pkg::REG_POS_X:        pos_x_reg        <= cfg_data;
                tirc_pkg::REG_POS_Y:        pos_y_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // radius squared only feeds the last pipeline stage, so registering it is fine
    always_comb begin
        radius_sq_next = box_x * box_x;
    end

    always_ff @(posedge aclk) begin
        radius_sq_reg <= radius_sq_next;
    end

    always_comb begin
        flags.mode = mode_reg;
        flags.swap = swap_reg;

        eff_w = (frame_width_reg  == '0) ? C'(1) : frame_width_reg;
        eff_h = (frame_height_reg == '0) ? C'(1) : frame_height_reg;

        if (size_x_reg == '0)       eff_sx = C'(1);
        else if (size_x_reg > eff_w) eff_sx = eff_w;
        else                        eff_sx = size_x_reg;

        if (size_y_reg == '0)       eff_sy = C'(1);
        else if (size_y_reg > eff_h) eff_sy = eff_h;
        else                        eff_sy = size_y_reg;

        eff_ox = (pos_x_reg < eff_w) ? pos_x_reg : eff_w;
        eff_oy = (pos_y_reg < eff_h) ? pos_y_reg : eff_h;

        box_x = (size_x_reg > C'(2)) ? size_x_reg : C'(2);
        box_y = (size_y_reg > C'(2)) ? size_y_reg : C'(2);
    end

    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign radius_sq = radius_sq_reg;

endmodule

// File: design/tirc_position.sv
// ----------------------------------------------------------------------------
// tirc_position
// Raster position tracker with stripe and band phase counters.
// ----------------------------------------------------------------------------
module tirc_position #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  frame_start,
    input  logic [COORD_BITS-1:0] eff_w,
    input  logic [COORD_BITS-1:0] eff_h,
    input  logic [COORD_BITS-1:0] eff_sx,
    input  logic [COORD_BITS-1:0] eff_sy,
    input  logic [COORD_BITS-1:0] eff_ox,
    input  logic [COORD_BITS-1:0] eff_oy,
    output logic [COORD_BITS-1:0] col,
    output logic [COORD_BITS-1:0] row,
    output tirc_pkg::pos_flags_t  pflags
);

    localparam int C = COORD_BITS;

    logic [C-1:0] column_reg, column_next;
    logic [C-1:0] row_reg, row_next;
    logic [C-1:0] stripe_count_reg, stripe_count_next;
    logic         stripe_parity_reg, stripe_parity_next;
    logic [C-1:0] band_count_reg, band_count_next;
    logic         band_parity_reg, band_parity_next;

    logic [C-1:0] sc_cur, bc_cur, sc_inc, bc_inc;
    logic         sp_cur, bp_cur;
    logic         last_col, last_row;

    always_comb begin
        // a frame start zeroes the position before this pixel is used
        col    = frame_start ? '0   : column_reg;
        row    = frame_start ? '0   : row_reg;
        sc_cur = frame_start ? '0   : stripe_count_reg;
        sp_cur = frame_start ? 1'b0 : stripe_parity_reg;
        bc_cur = frame_start ? '0   : band_count_reg;
        bp_cur = frame_start ? 1'b0 : band_parity_reg;

        last_col = ({1'b0, col} + (C+1)'(1)) >= {1'b0, eff_w};
        last_row = ({1'b0, row} + (C+1)'(1)) >= {1'b0, eff_h};

        pflags.vert      = (col >= eff_ox) & ~sp_cur;
        pflags.band      = (row >= eff_oy) & ~bp_cur;
        pflags.frame_end = last_col & last_row;

        sc_inc = sc_cur + C'(1);
        bc_inc = bc_cur + C'(1);

        column_next        = col;
        row_next           = row;
        stripe_count_next  = sc_cur;
        stripe_parity_next = sp_cur;
        band_count_next    = bc_cur;
        band_parity_next   = bp_cur;

        if (last_col) begin
            column_next        = '0;
            stripe_count_next  = '0;
            stripe_parity_next = 1'b0;
            if (last_row) begin
                row_next         = '0;
                band_count_next  = '0;
                band_parity_next = 1'b0;
            end else begin
                row_next = row + C'(1);
                if (row >= eff_oy) begin
                    if (bc_inc >= eff_sy) begin
                        band_count_next  = '0;
                        band_parity_next = ~bp_cur;
                    end else begin
                        band_count_next = bc_inc;
                    end
                end
            end
        end else begin
            column_next = col + C'(1);
            if (col >= eff_ox) begin
                if (sc_inc >= eff_sx) begin
                    stripe_count_next  = '0;
                    stripe_parity_next = ~sp_cur;
                end else begin
                    stripe_count_next = sc_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg        <= '0;
            row_reg           <= '0;
            stripe_count_reg  <= '0;
            stripe_parity_reg <= 1'b0;
            band_count_reg    <= '0;
            band_parity_reg   <= 1'b0;
        end else if (advance) begin
            column_reg        <= column_next;
            row_reg           <= row_next;
            stripe_count_reg  <= stripe_count_next;
            stripe_parity_reg <= stripe_parity_next;
            band_count_reg    <= band_count_next;
            band_parity_reg   <= band_parity_next;
        end
    end

endmodule

// File: design/tirc_pipe.sv
// ----------------------------------------------------------------------------
// tirc_pipe
// Three-stage selection pipeline: region decision, squares, disc compare.
// ----------------------------------------------------------------------------
module tirc_pipe #(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PIXEL_BITS-1:0]   pixel_first,
    input  logic [PIXEL_BITS-1:0]   pixel_second,
    input  tirc_pkg::cfg_flags_t    flags,
    input  tirc_pkg::pos_flags_t    pflags,
    input  logic [COORD_BITS-1:0]   col,
    input  logic [COORD_BITS-1:0]   row,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    input  logic [COORD_BITS-1:0]   box_x,
    input  logic [COORD_BITS-1:0]   box_y,
    input  logic [2*COORD_BITS-1:0] radius_sq,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PIXEL_BITS-1:0]   pixel_out,
    output logic                    took_other,
    output logic                    frame_end
);

    localparam int C = COORD_BITS;
    localparam int P = PIXEL_BITS;

    logic rdy1, rdy2, rdy3;

    // stage 1: region decision and distances
    logic           s1_valid_reg;
    logic [P-1:0]   s1_top_reg, s1_oth_reg;
    logic           s1_circle_reg, s1_flat_reg, s1_end_reg;
    logic [C:0]     s1_t_reg;
    logic [C-1:0]   s1_dy_reg;

    // stage 2: squared distances
    logic           s2_valid_reg;
    logic [P-1:0]   s2_top_reg, s2_oth_reg;
    logic           s2_circle_reg, s2_flat_reg, s2_end_reg;
    logic [2*C+1:0] s2_tsq_reg;
    logic [2*C-1:0] s2_dysq_reg;

    // stage 3: output register
    logic           s3_valid_reg;
    logic [P-1:0]   s3_pixel_reg;
    logic           s3_other_reg, s3_end_reg;

    logic           flat_next;
    logic           in_box;
    logic [C:0]     t_next;
    logic [C-1:0]   dy_next;
    logic [2*C+2:0] dist_sq;
    logic           other3;

    assign rdy3     = ~s3_valid_reg | out_ready;
    assign rdy2     = ~s2_valid_reg | rdy3;
    assign rdy1     = ~s1_valid_reg | rdy2;
    assign in_ready = rdy1;

    always_comb begin
        in_box = (({1'b0, col} + {1'b0, box_x}) >= {1'b0, pos_x})
               & ({1'b0, col} < ({1'b0, pos_x} + {1'b0, box_x}))
               & (({1'b0, row} + {1'b0, box_y}) >= {1'b0, pos_y})
               & ({1'b0, row} < ({1'b0, pos_y} + {1'b0, box_y}));

        unique case (flags.mode)
            tirc_pkg::MODE_VERT:    flat_next = pflags.vert;
            tirc_pkg::MODE_HORIZ:   flat_next = pflags.band;
            tirc_pkg::MODE_BOX:     flat_next = ~in_box;
            tirc_pkg::MODE_CHECKER: flat_next = pflags.vert ^ pflags.band;
            default:                flat_next = 1'b0;
        endcase

        // larger of (cx - x) and (x - cx + 1), never below one
        if (pos_x > col) t_next = {1'b0, pos_x} - {1'b0, col};
        else             t_next = {1'b0, col} - {1'b0, pos_x} + (C+1)'(1);

        dy_next = (pos_y >= row) ? (pos_y - row) : (row - pos_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (rdy1) s1_valid_reg <= in_valid;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_top_reg    <= flags.swap ? pixel_second : pixel_first;
            s1_oth_reg    <= flags.swap ? pixel_first  : pixel_second;
            s1_circle_reg <= (flags.mode == tirc_pkg::MODE_CIRCLE);
            s1_flat_reg   <= flat_next;
            s1_end_reg    <= pflags.frame_end;
            s1_t_reg      <= t_next;
            s1_dy_reg     <= dy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_top_reg    <= s1_top_reg;
            s2_oth_reg    <= s1_oth_reg;
            s2_circle_reg <= s1_circle_reg;
            s2_flat_reg   <= s1_flat_reg;
            s2_end_reg    <= s1_end_reg;
            s2_tsq_reg    <= s1_t_reg * s1_t_reg;
            s2_dysq_reg   <= s1_dy_reg * s1_dy_reg;
        end
    end

    always_comb begin
        dist_sq = {1'b0, s2_tsq_reg} + (2*C+3)'(s2_dysq_reg);
        other3  = s2_circle_reg ? (dist_sq > (2*C+3)'(radius_sq)) : s2_flat_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_pixel_reg <= other3 ? s2_oth_reg : s2_top_reg;
            s3_other_reg <= other3;
            s3_end_reg   <= s2_end_reg;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign pixel_out  = s3_pixel_reg;
    assign took_other = s3_other_reg;
    assign frame_end  = s3_end_reg;

endmodule

// File: design/two_image_region_compare_mixer.sv
// ----------------------------------------------------------------------------
// two_image_region_compare_mixer
// Split-screen wipe between two co-registered pixel streams.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata: pixel_first, pixel_second; tuser: frame_start
//  m_axis    out        tdata: pixel_out; tuser: took_other; tlast: frame_end
//  cfg       in         cfg_index selects register, cfg_data is its value
//
//  one pixel pair per clock unless m_axis stalls; each pair passes the pipeline stages in order
//  (region decision, squared distances, disc compare and output register)
//  the raster counters advance on every accepted transaction
//  a stall on m_axis holds each stage that is full; empty stages still fill
//  synchronous active-low reset restores registers and clears the counters
// ----------------------------------------------------------------------------
module two_image_region_compare_mixer #(
    parameter int COORD_BITS = 12,
    parameter int PIXEL_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel_first, pixel_second
    input  logic [((2*PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // frame_start
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // pixel_out
    output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // took_other
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [2:0]                            cfg_index,
    input  logic [COORD_BITS-1:0]                 cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int P     = PIXEL_BITS;
    localparam int OUT_W = ((P+7)/8)*8;

    tirc_pkg::cfg_flags_t flags;
    tirc_pkg::pos_flags_t pflags;
    logic [C-1:0]   eff_w, eff_h, eff_sx, eff_sy, eff_ox, eff_oy;
    logic [C-1:0]   box_x, box_y, pos_x, pos_y, col, row;
    logic [2*C-1:0] radius_sq;
    logic [P-1:0]   pixel_out;
    logic           in_accept;

    assign in_accept = s_axis_tvalid & s_axis_tready;

    tirc_cfg #(.COORD_BITS(C)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flags     (flags),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .eff_sx    (eff_sx),
        .eff_sy    (eff_sy),
        .eff_ox    (eff_ox),
        .eff_oy    (eff_oy),
        .box_x     (box_x),
        .box_y     (box_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .radius_sq (radius_sq)
    );

    tirc_position #(.COORD_BITS(C)) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (in_accept),
        .frame_start (s_axis_tuser),
        .eff_w       (eff_w),
        .eff_h       (eff_h),
        .eff_sx      (eff_sx),
        .eff_sy      (eff_sy),
        .eff_ox      (eff_ox),
        .eff_oy      (eff_oy),
        .col         (col),
        .row         (row),
        .pflags      (pflags)
    );

    tirc_pipe #(.COORD_BITS(C), .PIXEL_BITS(P)) u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .pixel_first  (s_axis_tdata[P-1:0]),
        .pixel_second (s_axis_tdata[2*P-1:P]),
        .flags        (flags),
        .pflags       (pflags),
        .col          (col),
        .row          (row),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .box_x        (box_x),
        .box_y        (box_y),
        .radius_sq    (radius_sq),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .pixel_out    (pixel_out),
        .took_other   (m_axis_tuser),
        .frame_end    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'(pixel_out);

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split-screen wipe mixer. Pixel pairs go in as
// directed cases first (field extremes, every mode, clamped sizes, centres
// off the frame, settings changed part-way through a frame), then as random
// frames under fresh register settings. A raster-tracking model in the
// scoreboard predicts each mixed pixel, and results are compared in order.
// ----------------------------------------------------------------------------

typedef struct {
    logic [23:0] pixel;
    logic        took_other;
    logic        frame_end;
} mixed_pixel_t;

class wipe_scoreboard;
    // register copies
    bit [2:0]  mode;
    bit        swap;
    bit [11:0] width_reg, height_reg, size_x_reg, size_y_reg, pos_x_reg, pos_y_reg;
    // raster position and stripe/band phase
    bit [11:0] column, row, stripe_cnt, band_cnt;
    bit        stripe_par, band_par;

    mixed_pixel_t expected_pixels[$];
    int           errors;

    function new();
        mode       = tirc_pkg::MODE_VERT;
        swap       = 1'b0;
        width_reg  = 12'd640;
        height_reg = 12'd480;
        size_x_reg = 12'd64;
        size_y_reg = 12'd48;
        pos_x_reg  = '0;
        pos_y_reg  = '0;
        column     = '0;
        row        = '0;
        stripe_cnt = '0;
        band_cnt   = '0;
        stripe_par = 1'b0;
        band_par   = 1'b0;
        errors     = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [11:0] val);
        case (idx)
            tirc_pkg::REG_MODE:         mode       = val[2:0];
            tirc_pkg::REG_SWAP_INPUTS:  swap       = val[0];
            tirc_pkg::REG_FRAME_WIDTH:  width_reg  = val;
            tirc_pkg::REG_FRAME_HEIGHT: height_reg = val;
            tirc_pkg::REG_SIZE_X:       size_x_reg = val;
            tirc_pkg::REG_SIZE_Y:       size_y_reg = val;
            tirc_pkg::REG_POS_X:        pos_x_reg  = val;
            tirc_pkg::REG_POS_Y:        pos_y_reg  = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    // work out the mixed pixel for one accepted pair and advance the raster
    function void note_pair(bit [23:0] pix_a, bit [23:0] pix_b, bit frame_start);
        int unsigned  w, h, sx, sy, ox, oy, col, rw, bx, by;
        int           r, a, t, dy;
        bit           vert, band, took, last_col, last_row, in_box;
        mixed_pixel_t e;

        if (frame_start) begin
            column     = '0;
            row        = '0;
            stripe_cnt = '0;
            band_cnt   = '0;
            stripe_par = 1'b0;
            band_par   = 1'b0;
        end

        w   = (width_reg == 0) ? 1 : width_reg;
        h   = (height_reg == 0) ? 1 : height_reg;
        sx  = (size_x_reg == 0) ? 1 : ((size_x_reg > w) ? w : size_x_reg);
        sy  = (size_y_reg == 0) ? 1 : ((size_y_reg > h) ? h : size_y_reg);
        ox  = (pos_x_reg < w) ? pos_x_reg : w;
        oy  = (pos_y_reg < h) ? pos_y_reg : h;
        col = column;
        rw  = row;

        vert = (col >= ox) && !stripe_par;
        band = (rw >= oy) && !band_par;

        case (mode)
            tirc_pkg::MODE_VERT:  took = vert;
            tirc_pkg::MODE_HORIZ: took = band;
            tirc_pkg::MODE_CIRCLE: begin
                // disc test on integer squares, column distance biased by one on the right
                r    = (size_x_reg > 2) ? size_x_reg : 2;
                a    = int'(pos_x_reg) - int'(col);
                t    = (a > 0) ? a : 1 - a;
                dy   = int'(pos_y_reg) - int'(rw);
                took = !(t * t + dy * dy <= r * r);
            end
            tirc_pkg::MODE_BOX: begin
                bx     = (size_x_reg > 2) ? size_x_reg : 2;
                by     = (size_y_reg > 2) ? size_y_reg : 2;
                in_box = (col + bx >= pos_x_reg) && (col < pos_x_reg + bx) &&
                         (rw + by >= pos_y_reg) && (rw < pos_y_reg + by);
                took   = !in_box;
            end
            tirc_pkg::MODE_CHECKER: took = vert != band;
            default:                took = 1'b0;
        endcase

        last_col = (col + 1 >= w);
        last_row = (rw + 1 >= h);

        if (took)
            e.pixel = swap ? pix_a : pix_b;
        else
            e.pixel = swap ? pix_b : pix_a;
        e.took_other = took;
        e.frame_end  = last_col && last_row;
        expected_pixels.push_back(e);

        if (last_col) begin
            column     = '0;
            stripe_cnt = '0;
            stripe_par = 1'b0;
            if (last_row) begin
                row      = '0;
                band_cnt = '0;
                band_par = 1'b0;
            end else begin
                row = 12'(rw + 1);
                if (rw >= oy) begin
                    band_cnt = band_cnt + 12'd1;
                    if (band_cnt >= sy) begin
                        band_cnt = '0;
                        band_par = ~band_par;
                    end
                end
            end
        end else begin
            column = 12'(col + 1);
            if (col >= ox) begin
                stripe_cnt = stripe_cnt + 12'd1;
                if (stripe_cnt >= sx) begin
                    stripe_cnt = '0;
                    stripe_par = ~stripe_par;
                end
            end
        end
    endfunction

    function void check_pixel(logic [23:0] pix, logic took, logic fe);
        mixed_pixel_t e;
        if (expected_pixels.size() == 0) begin
            errors++;
            if (errors <= 50)
                $display("%0t: unexpected result: pixel %h took_other %b frame_end %b",
                         $time, pix, took, fe);
            return;
        end
        e = expected_pixels.pop_front();
        if (pix !== e.pixel) begin
            errors++;
            if (errors <= 50)
                $display("%0t: pixel expected %h actual %h", $time, e.pixel, pix);
        end
        if (took !== e.took_other) begin
            errors++;
            if (errors <= 50)
                $display("%0t: took_other expected %b actual %b", $time, e.took_other, took);
        end
        if (fe !== e.frame_end) begin
            errors++;
            if (errors <= 50)
                $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, fe);
        end
    endfunction
endclass

module tb_top;

    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 1200;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 2000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index     = tirc_pkg::REG_MODE;
    logic [11:0] cfg_data      = '0;

    // no idling on either stream while set
    bit steady = 1'b0;

    wipe_scoreboard board = new();

    two_image_region_compare_mixer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 28);

    // every transaction is seen here, on pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                board.note_pair(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                board.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_pair(input bit [23:0] pix_a, input bit [23:0] pix_b,
                             input bit frame_start);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix_b, pix_a};
        s_axis_tuser  <= frame_start;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input bit [2:0] idx, input bit [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // upper bits of the data written to the mode and swap registers carry noise
    task automatic write_regs(input bit [2:0] md, input bit sw,
                              input bit [11:0] w, input bit [11:0] h,
                              input bit [11:0] sx, input bit [11:0] sy,
                              input bit [11:0] px, input bit [11:0] py);
        write_reg(tirc_pkg::REG_MODE, {9'($urandom), md});
        write_reg(tirc_pkg::REG_SWAP_INPUTS, {11'($urandom), sw});
        write_reg(tirc_pkg::REG_FRAME_WIDTH, w);
        write_reg(tirc_pkg::REG_FRAME_HEIGHT, h);
        write_reg(tirc_pkg::REG_SIZE_X, sx);
        write_reg(tirc_pkg::REG_SIZE_Y, sy);
        write_reg(tirc_pkg::REG_POS_X, px);
        write_reg(tirc_pkg::REG_POS_Y, py);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic bit [23:0] pick_pixel();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
        return 24'($urandom);
    endfunction

    function automatic bit [11:0] pick_dim();
        case ($urandom_range(0, 29))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd4095;
            default: return 12'($urandom_range(1, 12));
        endcase
    endfunction

    // sizes and positions around the frame, now and then at the ends of the range
    function automatic bit [11:0] pick_extent(bit [11:0] d);
        int top;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        top = int'(d) + 3;
        if (top > 4095)
            top = 4095;
        return 12'($urandom_range(0, top));
    endfunction

    function automatic bit [2:0] pick_mode();
        if ($urandom_range(0, 9) == 0)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(tirc_pkg::MODE_VERT, tirc_pkg::MODE_CHECKER));
    endfunction

    initial begin : stimulus
        int        phase, sent, count;
        bit [11:0] w, h;
        bit        fs;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults straight out of reset
        send_pair(24'h000000, 24'hffffff, 1'b1);
        send_pair(24'hffffff, 24'h000000, 1'b0);
        send_pair(pick_pixel(), pick_pixel(), 1'b0);
        drain();

        // every mode on a tiny frame: zero and oversize sizes, centre off the frame,
        // settings changed without a new frame start
        for (int m = 0; m < 8; m++) begin
            write_regs(3'(m), m[0], 12'd3, 12'd2, 12'd0, 12'd4095, 12'd4095, 12'd1);
            send_pair(24'hffffff, 24'h000000, m == 0);
            send_pair(24'h000000, 24'hffffff, 1'b0);
            drain();
        end

        // zero frame size reads as one pixel
        write_regs(tirc_pkg::MODE_CHECKER, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_pair(pick_pixel(), pick_pixel(), 1'b1);
        send_pair(pick_pixel(), pick_pixel(), 1'b0);
        drain();

        phase = 0;
        sent  = 0;
        while (sent < ITEM_TARGET) begin
            steady = (phase >= 6) && (phase < 10);
            w = pick_dim();
            h = pick_dim();
            write_regs(pick_mode(), 1'($urandom_range(0, 1)), w, h,
                       pick_extent(w), pick_extent(h), pick_extent(w), pick_extent(h));
            count = $urandom_range(20, 80);
            for (int i = 0; i < count; i++) begin
                // mostly whole frames, sometimes a restart part-way through
                if (i == 0)
                    fs = ($urandom_range(0, 99) < 85);
                else
                    fs = ($urandom_range(0, 99) < 3);
                send_pair(pick_pixel(), pick_pixel(), fs);
            end
            sent += count;
            phase++;
            drain();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES * 4) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
